// File: src/nidc_pkg.sv
// Package for the national ID number checker: payload types, constants, helper functions.
package nidc_pkg;

   localparam int unsigned ID_LENGTH = 11;
   localparam int unsigned SUM_LENGTH = 10;
   localparam int unsigned LEAD_DIGITS = 6;

   localparam logic [3:0] COUNT_MAX = 4'd15;
   localparam logic [3:0] POS_TENTH = 4'd9;
   localparam logic [3:0] POS_LAST = 4'd10;

   localparam logic [7:0] ASCII_ZERO = 8'h30;
   localparam logic [7:0] ASCII_NINE = 8'h39;

   localparam logic [11:0] YEAR_1900 = 12'd1900;
   localparam logic [11:0] YEAR_2000 = 12'd2000;
   localparam logic [11:0] YEAR_2100 = 12'd2100;
   localparam logic [11:0] YEAR_2200 = 12'd2200;
   localparam logic [11:0] YEAR_2300 = 12'd2300;
   localparam logic [11:0] YEAR_MAX = 12'd2399;

   localparam logic [4:0] MONTH_JAN = 5'd1;
   localparam logic [4:0] MONTH_FEB = 5'd2;
   localparam logic [4:0] MONTH_APR = 5'd4;
   localparam logic [4:0] MONTH_JUN = 5'd6;
   localparam logic [4:0] MONTH_SEP = 5'd9;
   localparam logic [4:0] MONTH_NOV = 5'd11;
   localparam logic [4:0] MONTH_DEC = 5'd12;
   localparam logic [4:0] MONTH_MAX = 5'd19;

   localparam logic [6:0] DAYS_LEAP_FEB = 7'd29;
   localparam logic [6:0] DAYS_FEB = 7'd28;
   localparam logic [6:0] DAYS_SHORT = 7'd30;
   localparam logic [6:0] DAYS_LONG = 7'd31;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_string;
   } req_payload_type;

   typedef struct packed {
      logic        well_formed;
      logic        date_valid;
      logic        check_ok;
      logic        is_female;
      logic [6:0]  birth_day;
      logic [4:0]  birth_month;
      logic [11:0] birth_year;
   } rsp_payload_type;

   // Weights 1,3,7,9 repeat every four positions.
   function automatic logic [3:0] digit_weight(input logic [3:0] pos);
      logic [3:0] w;
      case (pos[1:0])
         2'd0: w = 4'd1;
         2'd1: w = 4'd3;
         2'd2: w = 4'd7;
         default: w = 4'd9;
      endcase
      return w;
   endfunction

   // Remainder by ten for values below 128: quotient = (v * 205) >> 11.
   function automatic logic [3:0] mod_ten(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  quo;
      logic [6:0]  rem;
      prod = 15'(v) * 15'd205;
      quo = prod[14:11];
      rem = v - 7'({quo, 3'b000} + {quo, 1'b0});
      return rem[3:0];
   endfunction

   function automatic logic [6:0] times_ten(input logic [3:0] d);
      return 7'({d, 3'b000}) + 7'({d, 1'b0});
   endfunction

   function automatic logic [11:0] century_base(input logic [2:0] c);
      logic [11:0] b;
      case (c)
         3'd0: b = YEAR_1900;
         3'd1: b = YEAR_2000;
         3'd2: b = YEAR_2100;
         3'd3: b = YEAR_2200;
         default: b = YEAR_2300;
      endcase
      return b;
   endfunction

endpackage

// File: src/national_id_number_checker_top.sv
// Top level of the national ID number checker: character stream in, one verdict per string out.
//
// Characters of an ID number enter on the req_ channel, one per transfer, first character
// first; req_data.end_of_string marks the last one. Each string ends in exactly one transfer
// on the rsp_ channel with the format, date, check digit and sex flags and the decoded date.
// Characters that do not end a string produce nothing.
// A character is registered on transfer into the input register, then folded into the
// running sum and digit store; for the last character the verdict is registered into the
// result register in that same step, which raises rsp_valid. One character per cycle is
// sustained; the only limit is the single result register.
// While a result waits for rsp_ready, characters that do not end a string keep flowing; an
// end-of-string character holds in the input register until the result register frees up.
// Reset clears the running state and both valid flags; the first transfer after reset starts
// a new string.
module national_id_number_checker_top (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  nidc_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output nidc_pkg::rsp_payload_type rsp_data
);

   logic                      in_valid_ff, in_valid_in;
   nidc_pkg::req_payload_type in_data_ff;

   logic [3:0] count_ff, count_in;
   logic       bad_ff, bad_in;
   logic [3:0] sum_ff, sum_in;
   logic [3:0] digits_ff [nidc_pkg::LEAD_DIGITS];
   logic [3:0] digits_in [nidc_pkg::LEAD_DIGITS];
   logic       tenth_even_ff, tenth_even_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   nidc_pkg::rsp_payload_type rsp_data_ff, rsp_data_in;

   logic       out_free, step;
   logic       is_digit;
   logic [3:0] digit;
   logic [6:0] sum_total;
   logic       wf;
   logic [3:0] expect_digit;
   logic [2:0] century;
   logic [6:0] year_low, day;
   logic [4:0] month;
   logic [11:0] year;
   logic       leap;
   logic [6:0] last_day;
   logic       date_ok;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign step = in_valid_ff && (!in_data_ff.end_of_string || out_free);
   assign req_ready = !in_valid_ff || step;
   assign in_valid_in = req_valid ? 1'b1 : (in_valid_ff && !step);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Per-character update of the running state
   always_comb begin
      is_digit = (in_data_ff.character >= nidc_pkg::ASCII_ZERO) &&
                 (in_data_ff.character <= nidc_pkg::ASCII_NINE);
      digit = is_digit ? in_data_ff.character[3:0] : 4'd0;
      sum_total = 7'(nidc_pkg::digit_weight(count_ff) * digit) + 7'(sum_ff);

      count_in = (count_ff < nidc_pkg::COUNT_MAX) ? count_ff + 4'd1 : count_ff;
      bad_in = bad_ff;
      sum_in = sum_ff;
      tenth_even_in = tenth_even_ff;
      for (int i = 0; i < nidc_pkg::LEAD_DIGITS; i++) begin
         digits_in[i] = digits_ff[i];
      end

      if (count_ff < 4'(nidc_pkg::ID_LENGTH) && !is_digit) begin
         bad_in = 1'b1;
      end
      if (count_ff < 4'(nidc_pkg::SUM_LENGTH)) begin
         sum_in = nidc_pkg::mod_ten(sum_total);
         for (int i = 0; i < nidc_pkg::LEAD_DIGITS; i++) begin
            if (count_ff == 4'(i)) begin
               digits_in[i] = digit;
            end
         end
         if (count_ff == nidc_pkg::POS_TENTH) begin
            tenth_even_in = !digit[0];
         end
      end

      // End of string starts the next string from scratch
      if (in_data_ff.end_of_string) begin
         count_in = 4'd0;
         bad_in = 1'b0;
         sum_in = 4'd0;
         tenth_even_in = 1'b0;
         for (int i = 0; i < nidc_pkg::LEAD_DIGITS; i++) begin
            digits_in[i] = 4'd0;
         end
      end
   end

   // Verdict for the final character; stored digits come from earlier characters
   always_comb begin
      wf = (count_ff == nidc_pkg::POS_LAST) && !bad_ff && is_digit;
      expect_digit = (sum_ff == 4'd0) ? 4'd0 : 4'd10 - sum_ff;
      century = digits_ff[2][3:1];
      month = (digits_ff[2][0] ? 5'd10 : 5'd0) + 5'(digits_ff[3]);
      day = nidc_pkg::times_ten(digits_ff[4]) + 7'(digits_ff[5]);
      year_low = nidc_pkg::times_ten(digits_ff[0]) + 7'(digits_ff[1]);
      year = nidc_pkg::century_base(century) + 12'(year_low);
      // Every century base is a multiple of four; only 2000 is a multiple of 400
      leap = (year_low == 7'd0) ? (century == 3'd1) : (year_low[1:0] == 2'b00);
      if (month == nidc_pkg::MONTH_FEB) begin
         last_day = leap ? nidc_pkg::DAYS_LEAP_FEB : nidc_pkg::DAYS_FEB;
      end else if (month == nidc_pkg::MONTH_APR || month == nidc_pkg::MONTH_JUN ||
                   month == nidc_pkg::MONTH_SEP || month == nidc_pkg::MONTH_NOV) begin
         last_day = nidc_pkg::DAYS_SHORT;
      end else begin
         last_day = nidc_pkg::DAYS_LONG;
      end
      date_ok = (month >= nidc_pkg::MONTH_JAN) && (month <= nidc_pkg::MONTH_DEC) &&
                (day != 7'd0) && (day <= last_day);

      rsp_data_in.well_formed = wf;
      rsp_data_in.date_valid = wf && date_ok;
      rsp_data_in.check_ok = wf && (expect_digit == digit);
      rsp_data_in.is_female = wf && tenth_even_ff;
      rsp_data_in.birth_day = wf ? day : 7'd0;
      rsp_data_in.birth_month = wf ? month : 5'd0;
      rsp_data_in.birth_year = wf ? year : 12'd0;

      if (step && in_data_ff.end_of_string) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_ready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 4'd0;
         bad_ff <= 1'b0;
         sum_ff <= 4'd0;
         tenth_even_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < nidc_pkg::LEAD_DIGITS; i++) begin
            digits_ff[i] <= 4'd0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (step) begin
            count_ff <= count_in;
            bad_ff <= bad_in;
            sum_ff <= sum_in;
            tenth_even_ff <= tenth_even_in;
            for (int i = 0; i < nidc_pkg::LEAD_DIGITS; i++) begin
               digits_ff[i] <= digits_in[i];
            end
         end
      end
      if (step && in_data_ff.end_of_string) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

`ifndef SYNTHESIS
   a_reject_zero_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.well_formed |->
         !rsp_data.date_valid && !rsp_data.check_ok && !rsp_data.is_female &&
         rsp_data.birth_day == 7'd0 && rsp_data.birth_month == 5'd0 &&
         rsp_data.birth_year == 12'd0)
      else $error("rejected string carries nonzero fields");

   a_accept_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.well_formed |->
         rsp_data.birth_year >= nidc_pkg::YEAR_1900 &&
         rsp_data.birth_year <= nidc_pkg::YEAR_MAX &&
         rsp_data.birth_month <= nidc_pkg::MONTH_MAX)
      else $error("decoded date out of range");

   a_state_cleared: assert property (@(posedge clock) disable iff (reset)
      step && in_data_ff.end_of_string |=> count_ff == 4'd0 && sum_ff == 4'd0 && !bad_ff)
      else $error("state not cleared after end of string");

   a_stage_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !step |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a pending character");
`endif

endmodule
